@@ rtl/core/apms_pkg.sv @@
// Shared types, codes and helper functions of the aging priority scheduler.
`default_nettype none

package apms_pkg;

    // Operation codes of an input beat
    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_POP  = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_APPLY = 2'd2
    } t_state;

    // Status codes of a result beat
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    localparam logic [1:0] LEVEL_HIGH   = 2'd2;
    localparam int         LEVEL_WEIGHT = 10;
    localparam logic [7:0] THR_RESET    = 8'd5;

    // Input beat
    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] message_id;
        logic [1:0]  priority_req;
    } t_in;

    // Result beat
    typedef struct packed {
        logic        out_valid;
        logic [15:0] out_message_id;
        logic [1:0]  out_priority;
        logic [1:0]  status;
        logic [4:0]  pending_count;
        logic [15:0] boost_count;
    } t_out;

    // Command broadcast to every cell
    typedef struct packed {
        logic apply;
        t_op  op;
    } t_cell_cmd;

    // Score contribution of a level
    function automatic logic [4:0] f_level_weight(input logic [1:0] level);
        logic [4:0] w;
        case (level)
            2'd0:    w = 5'd0;
            2'd1:    w = 5'(LEVEL_WEIGHT);
            default: w = 5'(2 * LEVEL_WEIGHT);
        endcase
        return w;
    endfunction

    // Clamp a requested level to high
    function automatic logic [1:0] f_sat_level(input logic [1:0] req);
        return (req > LEVEL_HIGH) ? LEVEL_HIGH : req;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/aging_priority_message_scheduler.sv @@
// Top level of the aging priority message scheduler: a row of slot cells and a sequencer.
//
//   channel   | ports                                  | handshake
//   ----------+----------------------------------------+---------------------------
//   command   | start, busy, i_in                      | beat taken when start & !busy
//   result    | o_done, o_out                          | one-cycle strobe, no stall
//   config    | i_cfg_valid, o_cfg_ready, i_cfg_data   | beat taken when valid & ready
//
// Add and the unused op go from idle straight to the apply state, which registers the
// result beat; pop and aging tick first step through the scan state, whose length is set
// by the argmax and boost-count chains that move one cell per cycle through the row. busy
// stays high until the result is registered, and a new command may be given in the cycle
// of the strobe. Reset empties the queue, clears the boost total and sets the threshold
// to 5. The result side cannot stall.
`default_nettype none

module aging_priority_message_scheduler #(
    parameter int QUEUE_DEPTH = 16,
    parameter int AGE_BITS    = 8,
    parameter int ID_BITS     = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire apms_pkg::t_in  i_in,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [7:0]     i_cfg_data,
    output apms_pkg::t_out      o_out,
    output logic                o_done
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AGE_BITS + 2;

    apms_pkg::t_cell_cmd w_cmd;
    logic [IW-1:0]       w_target;
    logic [7:0]          w_thr;
    logic [ID_BITS-1:0]  w_new_id;
    logic [1:0]          w_new_level;

    logic                w_valid [QUEUE_DEPTH];
    logic [ID_BITS-1:0]  w_id    [QUEUE_DEPTH];
    logic [1:0]          w_level [QUEUE_DEPTH];
    logic [AGE_BITS-1:0] w_age   [QUEUE_DEPTH];
    logic                w_cvld  [QUEUE_DEPTH];
    logic [SW-1:0]       w_cscore[QUEUE_DEPTH];
    logic [IW-1:0]       w_cidx  [QUEUE_DEPTH];
    logic [ID_BITS-1:0]  w_cid   [QUEUE_DEPTH];
    logic [1:0]          w_clvl  [QUEUE_DEPTH];
    logic [CW-1:0]       w_boost [QUEUE_DEPTH];

    // row of slot cells, slot 0 at the head of the queue
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                l_up_valid;
        logic [ID_BITS-1:0]  l_up_id;
        logic [1:0]          l_up_level;
        logic [AGE_BITS-1:0] l_up_age;
        logic                l_cvld;
        logic [SW-1:0]       l_cscore;
        logic [IW-1:0]       l_cidx;
        logic [ID_BITS-1:0]  l_cid;
        logic [1:0]          l_clvl;
        logic [CW-1:0]       l_boost;

        // feed the compaction path from the slot above
        if (g == QUEUE_DEPTH - 1) begin : g_top
            assign l_up_valid = 1'b0;
            assign l_up_id    = '0;
            assign l_up_level = '0;
            assign l_up_age   = '0;
        end else begin : g_mid
            assign l_up_valid = w_valid[g+1];
            assign l_up_id    = w_id[g+1];
            assign l_up_level = w_level[g+1];
            assign l_up_age   = w_age[g+1];
        end

        // feed the chains from the slot below
        if (g == 0) begin : g_head
            assign l_cvld   = 1'b0;
            assign l_cscore = '0;
            assign l_cidx   = '0;
            assign l_cid    = '0;
            assign l_clvl   = '0;
            assign l_boost  = '0;
        end else begin : g_rest
            assign l_cvld   = w_cvld[g-1];
            assign l_cscore = w_cscore[g-1];
            assign l_cidx   = w_cidx[g-1];
            assign l_cid    = w_cid[g-1];
            assign l_clvl   = w_clvl[g-1];
            assign l_boost  = w_boost[g-1];
        end

        apms_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .AGE_BITS    (AGE_BITS),
            .ID_BITS     (ID_BITS),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_target     (w_target),
            .i_thr        (w_thr),
            .i_new_id     (w_new_id),
            .i_new_level  (w_new_level),
            .i_up_valid   (l_up_valid),
            .i_up_id      (l_up_id),
            .i_up_level   (l_up_level),
            .i_up_age     (l_up_age),
            .i_cand_vld   (l_cvld),
            .i_cand_score (l_cscore),
            .i_cand_idx   (l_cidx),
            .i_cand_id    (l_cid),
            .i_cand_lvl   (l_clvl),
            .i_boost      (l_boost),
            .o_valid      (w_valid[g]),
            .o_id         (w_id[g]),
            .o_level      (w_level[g]),
            .o_age        (w_age[g]),
            .o_cand_vld   (w_cvld[g]),
            .o_cand_score (w_cscore[g]),
            .o_cand_idx   (w_cidx[g]),
            .o_cand_id    (w_cid[g]),
            .o_cand_lvl   (w_clvl[g]),
            .o_boost      (w_boost[g])
        );
    end

    // sequencer and result register
    apms_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_in         (i_in),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_out        (o_out),
        .o_done       (o_done),
        .o_cmd        (w_cmd),
        .o_target     (w_target),
        .o_thr        (w_thr),
        .o_new_id     (w_new_id),
        .o_new_level  (w_new_level),
        .i_tail_vld   (w_cvld[QUEUE_DEPTH-1]),
        .i_tail_idx   (w_cidx[QUEUE_DEPTH-1]),
        .i_tail_id    (w_cid[QUEUE_DEPTH-1]),
        .i_tail_lvl   (w_clvl[QUEUE_DEPTH-1]),
        .i_tail_boost (w_boost[QUEUE_DEPTH-1])
    );

endmodule

`default_nettype wire

@@ rtl/core/apms_cell.sv @@
// One queue slot: entry storage plus one stage of the argmax and boost-count chains.
`default_nettype none

module apms_cell #(
    parameter int QUEUE_DEPTH = 16,
    parameter int AGE_BITS    = 8,
    parameter int ID_BITS     = 16,
    parameter int CELL_IDX    = 0
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire apms_pkg::t_cell_cmd               i_cmd,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]    i_target,
    input  wire logic [7:0]                        i_thr,
    input  wire logic [ID_BITS-1:0]                i_new_id,
    input  wire logic [1:0]                        i_new_level,
    // entry of the next slot up, for compaction
    input  wire logic                              i_up_valid,
    input  wire logic [ID_BITS-1:0]                i_up_id,
    input  wire logic [1:0]                        i_up_level,
    input  wire logic [AGE_BITS-1:0]               i_up_age,
    // chain stage from the slot below
    input  wire logic                              i_cand_vld,
    input  wire logic [AGE_BITS+1:0]               i_cand_score,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]    i_cand_idx,
    input  wire logic [ID_BITS-1:0]                i_cand_id,
    input  wire logic [1:0]                        i_cand_lvl,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]  i_boost,
    // own entry
    output logic                                   o_valid,
    output logic [ID_BITS-1:0]                     o_id,
    output logic [1:0]                             o_level,
    output logic [AGE_BITS-1:0]                    o_age,
    // chain stage toward the slot above
    output logic                                   o_cand_vld,
    output logic [AGE_BITS+1:0]                    o_cand_score,
    output logic [$clog2(QUEUE_DEPTH)-1:0]         o_cand_idx,
    output logic [ID_BITS-1:0]                     o_cand_id,
    output logic [1:0]                             o_cand_lvl,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]       o_boost
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AGE_BITS + 2;
    localparam int TW = (AGE_BITS > 8) ? AGE_BITS : 8;
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic                r_valid;
    logic [ID_BITS-1:0]  r_id;
    logic [1:0]          r_level;
    logic [AGE_BITS-1:0] r_age;

    logic                r_cand_vld;
    logic [SW-1:0]       r_cand_score;
    logic [IW-1:0]       r_cand_idx;
    logic [ID_BITS-1:0]  r_cand_id;
    logic [1:0]          r_cand_lvl;
    logic [CW-1:0]       r_boost;

    logic [SW-1:0]       w_score;
    logic                w_take_own;
    logic                w_boost;
    logic [AGE_BITS-1:0] w_age_inc;
    logic [AGE_BITS-1:0] w_up_age_inc;

    // score and boost condition of the held entry
    assign w_score    = SW'(apms_pkg::f_level_weight(r_level)) + SW'(r_age);
    assign w_take_own = r_valid && (!i_cand_vld || (w_score > i_cand_score));
    assign w_boost    = r_valid && (TW'(r_age) >= TW'(i_thr))
                        && (r_level < apms_pkg::LEVEL_HIGH);

    // saturating age steps
    assign w_age_inc    = (r_age == {AGE_BITS{1'b1}}) ? r_age : r_age + 1'b1;
    assign w_up_age_inc = (i_up_age == {AGE_BITS{1'b1}}) ? i_up_age : i_up_age + 1'b1;

    // advance the argmax and boost-count chains every cycle
    always_ff @(posedge i_clk) begin
        r_cand_vld <= w_take_own || i_cand_vld;
        if (w_take_own) begin
            r_cand_score <= w_score;
            r_cand_idx   <= MY_IDX;
            r_cand_id    <= r_id;
            r_cand_lvl   <= r_level;
        end else begin
            r_cand_score <= i_cand_score;
            r_cand_idx   <= i_cand_idx;
            r_cand_id    <= i_cand_id;
            r_cand_lvl   <= i_cand_lvl;
        end
        r_boost <= i_boost + CW'(w_boost);
    end

    // slot valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.apply) begin
            case (i_cmd.op)
                apms_pkg::OP_ADD: begin
                    if (i_target == MY_IDX) begin
                        r_valid <= 1'b1;
                    end
                end
                apms_pkg::OP_POP: begin
                    if (MY_IDX >= i_target) begin
                        r_valid <= i_up_valid;
                    end
                end
                default: begin
                    r_valid <= r_valid;
                end
            endcase
        end
    end

    // slot payload: append, compact and age, or boost
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            case (i_cmd.op)
                apms_pkg::OP_ADD: begin
                    if (i_target == MY_IDX) begin
                        r_id    <= i_new_id;
                        r_level <= i_new_level;
                        r_age   <= '0;
                    end
                end
                apms_pkg::OP_POP: begin
                    if (MY_IDX >= i_target) begin
                        r_id    <= i_up_id;
                        r_level <= i_up_level;
                        r_age   <= w_up_age_inc;
                    end else begin
                        r_age <= w_age_inc;
                    end
                end
                apms_pkg::OP_TICK: begin
                    if (w_boost) begin
                        r_level <= r_level + 1'b1;
                        r_age   <= '0;
                    end
                end
                default: begin
                    r_age <= r_age;
                end
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_id         = r_id;
    assign o_level      = r_level;
    assign o_age        = r_age;
    assign o_cand_vld   = r_cand_vld;
    assign o_cand_score = r_cand_score;
    assign o_cand_idx   = r_cand_idx;
    assign o_cand_id    = r_cand_id;
    assign o_cand_lvl   = r_cand_lvl;
    assign o_boost      = r_boost;

endmodule

`default_nettype wire

@@ rtl/core/apms_ctrl.sv @@
// Sequencer, fill count, boost total, threshold register and result register.
`default_nettype none

module apms_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire apms_pkg::t_in                     i_in,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [7:0]                        i_cfg_data,
    output apms_pkg::t_out                         o_out,
    output logic                                   o_done,
    // cell side
    output apms_pkg::t_cell_cmd                    o_cmd,
    output logic [$clog2(QUEUE_DEPTH)-1:0]         o_target,
    output logic [7:0]                             o_thr,
    output logic [ID_BITS-1:0]                     o_new_id,
    output logic [1:0]                             o_new_level,
    input  wire logic                              i_tail_vld,
    input  wire logic [$clog2(QUEUE_DEPTH)-1:0]    i_tail_idx,
    input  wire logic [ID_BITS-1:0]                i_tail_id,
    input  wire logic [1:0]                        i_tail_lvl,
    input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]  i_tail_boost
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
    localparam logic [IW-1:0] LAST_STEP = IW'(QUEUE_DEPTH - 1);

    apms_pkg::t_state r_state, n_state;
    apms_pkg::t_op    r_op;
    logic [ID_BITS-1:0] r_id;
    logic [1:0]         r_lvl;
    logic [IW-1:0]      r_step, n_step;
    logic [CW-1:0]      r_count, n_count;
    logic [15:0]        r_boost, n_boost;
    logic [7:0]         r_thr;
    apms_pkg::t_out     r_out, n_out;
    logic               r_done, n_done;
    logic               w_accept;
    logic               w_full;
    logic               w_empty;

    assign w_accept = start && !busy;
    assign w_full   = (r_count == FULL_CNT);
    assign w_empty  = (r_count == '0);

    // state and bookkeeping registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apms_pkg::ST_IDLE;
            r_step  <= '0;
            r_count <= '0;
            r_boost <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_count <= n_count;
            r_boost <= n_boost;
            r_done  <= n_done;
        end
    end

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= apms_pkg::THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // latch the accepted beat; hold the result beat
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= apms_pkg::t_op'(i_in.op);
            r_id  <= ID_BITS'(i_in.message_id);
            r_lvl <= apms_pkg::f_sat_level(i_in.priority_req);
        end
        r_out <= n_out;
    end

    // next state, cell command and result
    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_count  = r_count;
        n_boost  = r_boost;
        n_done   = 1'b0;
        n_out    = r_out;
        o_cmd    = '{apply: 1'b0, op: apms_pkg::OP_NONE};
        o_target = (r_op == apms_pkg::OP_ADD) ? r_count[IW-1:0] : i_tail_idx;
        case (r_state)
            apms_pkg::ST_IDLE: begin
                n_step = '0;
                if (w_accept) begin
                    if (i_in.op == apms_pkg::OP_POP || i_in.op == apms_pkg::OP_TICK) begin
                        n_state = apms_pkg::ST_SCAN;
                    end else begin
                        n_state = apms_pkg::ST_APPLY;
                    end
                end
            end
            apms_pkg::ST_SCAN: begin
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state = apms_pkg::ST_APPLY;
                end
            end
            apms_pkg::ST_APPLY: begin
                n_state                = apms_pkg::ST_IDLE;
                n_done                 = 1'b1;
                n_out.out_valid        = 1'b0;
                n_out.out_message_id   = '0;
                n_out.out_priority     = '0;
                n_out.status           = apms_pkg::STATUS_OK;
                o_cmd.apply            = 1'b1;
                o_cmd.op               = r_op;
                case (r_op)
                    apms_pkg::OP_ADD: begin
                        if (w_full) begin
                            o_cmd.op     = apms_pkg::OP_NONE;
                            n_out.status = apms_pkg::STATUS_FULL;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    apms_pkg::OP_POP: begin
                        if (w_empty) begin
                            o_cmd.op     = apms_pkg::OP_NONE;
                            n_out.status = apms_pkg::STATUS_EMPTY;
                        end else begin
                            n_count              = r_count - 1'b1;
                            n_out.out_valid      = i_tail_vld;
                            n_out.out_message_id = 16'(i_tail_id);
                            n_out.out_priority   = i_tail_lvl;
                        end
                    end
                    apms_pkg::OP_TICK: begin
                        n_boost = r_boost + 16'(i_tail_boost);
                    end
                    default: begin
                        o_cmd.op = apms_pkg::OP_NONE;
                    end
                endcase
                n_out.pending_count = 5'(n_count);
                n_out.boost_count   = n_boost;
            end
            default: begin
                n_state = apms_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy        = (r_state != apms_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out       = r_out;
    assign o_done      = r_done;
    assign o_thr       = r_thr;
    assign o_new_id    = r_id;
    assign o_new_level = r_lvl;

endmodule

`default_nettype wire
